// File: src/prrs_pkg.sv
// ----------------------------------------------------------------------------
// prrs_pkg: shared definitions of the priority round-robin scheduler
// Event codes, status codes and the small structs that pass between the
// controller and the cells of the task chain.
// ----------------------------------------------------------------------------
package prrs_pkg;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_EXIT = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NO_TASK = 2'd2;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic insert;  // open a slot and place the new task
    logic shift;   // close the gap left by the removed task
  } prrs_cmd_t;

  // Flags a cell hands to its right-hand neighbor.
  typedef struct packed {
    logic keep;    // this entry stays ahead of the task being added
    logic match;   // this entry holds the running task
    logic after;   // the running task sits here or further left
  } prrs_link_t;

endpackage

// File: src/prrs_cell.sv
// ----------------------------------------------------------------------------
// prrs_cell: one slot of the sorted task list
// Holds one list entry (id and priority), takes part in the insert and
// remove shifts, and passes the search results one slot per cycle.
// ----------------------------------------------------------------------------
module prrs_cell
  import prrs_pkg::*;
#(
  parameter int ID_W   = 4,
  parameter int PRIO_W = 5
) (
  input  logic              clk_i,
  input  prrs_cmd_t         cmd_i,
  input  logic              occupied_i,
  input  logic [ID_W-1:0]   run_id_i,
  input  logic [PRIO_W-1:0] run_prio_i,
  input  logic [ID_W-1:0]   new_id_i,
  input  logic [PRIO_W-1:0] new_prio_i,
  input  prrs_link_t        left_link_i,
  input  logic [ID_W-1:0]   left_id_i,
  input  logic [PRIO_W-1:0] left_prio_i,
  input  logic [ID_W-1:0]   right_id_i,
  input  logic [PRIO_W-1:0] right_prio_i,
  input  logic              left_hit_vld_i,
  input  logic [ID_W-1:0]   left_hit_id_i,
  input  logic [PRIO_W-1:0] left_hit_prio_i,
  output prrs_link_t        link_o,
  output logic [ID_W-1:0]   id_o,
  output logic [PRIO_W-1:0] prio_o,
  output logic              hit_vld_o,
  output logic [ID_W-1:0]   hit_id_o,
  output logic [PRIO_W-1:0] hit_prio_o
);

  logic [ID_W-1:0]   id_q, id_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic              after_q;
  logic              hit_vld_q;
  logic [ID_W-1:0]   hit_id_q;
  logic [PRIO_W-1:0] hit_prio_q;
  logic              keep, match, succ;

  assign keep  = occupied_i && (new_prio_i < prio_q);
  assign match = occupied_i && (id_q == run_id_i);
  // The successor of the running task qualifies only at equal or higher priority.
  assign succ  = occupied_i && left_link_i.match && (prio_q >= run_prio_i);

  always_comb begin
    id_d   = id_q;
    prio_d = prio_q;
    if (cmd_i.insert && !keep) begin
      if (left_link_i.keep) begin
        id_d   = new_id_i;
        prio_d = new_prio_i;
      end else begin
        id_d   = left_id_i;
        prio_d = left_prio_i;
      end
    end else if (cmd_i.shift && after_q) begin
      id_d   = right_id_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    prio_q  <= prio_d;
    after_q <= match || left_link_i.after;
    if (succ) begin
      hit_vld_q  <= 1'b1;
      hit_id_q   <= id_q;
      hit_prio_q <= prio_q;
    end else begin
      hit_vld_q  <= left_hit_vld_i;
      hit_id_q   <= left_hit_id_i;
      hit_prio_q <= left_hit_prio_i;
    end
  end

  assign link_o     = '{keep: keep, match: match, after: after_q};
  assign id_o       = id_q;
  assign prio_o     = prio_q;
  assign hit_vld_o  = hit_vld_q;
  assign hit_id_o   = hit_id_q;
  assign hit_prio_o = hit_prio_q;

endmodule

// File: src/priority_round_robin_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_top: priority task scheduler, round robin
// among equal priorities
// Events arrive on the slave stream, one result beat per event leaves on the
// master stream. Input tdata holds, from the lowest bit up: mode,
// priority_req. Output tdata holds, from the lowest bit up: status,
// new_task_id, running_valid, running_id.
// An add, an exit with no task running and an unused mode go from idle
// straight to the state that loads the result register. A tick or an exit
// walks the chain of task cells once, the search results moving one cell per
// cycle, and then loads its result; an exit with a running task adds the
// remove shift between the walk and the load.
// One event is processed at a time; tready is high only while idle, so the
// next event can be accepted once the result is loaded, even while that
// beat still waits.
// Reset empties the task list, restarts id numbering at zero and leaves no
// task running. When the receiver stalls, the finished result is held in the
// output register, and a following event stops before its result until the
// register is free.
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler_top
  import prrs_pkg::*;
#(
  parameter int MAX_TASKS     = 16,
  parameter int PRIORITY_BITS = 5,
  localparam int ID_W   = $clog2(MAX_TASKS),
  localparam int IN_W   = 2 + PRIORITY_BITS,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = 3 + 2 * ID_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [IN_TW-1:0]  s_axis_tdata_i,   // mode, priority_req
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_TW-1:0] m_axis_tdata_o    // status, new_task_id,
                                              // running_valid, running_id
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_WALK,
    ST_SHIFT,
    ST_SELECT,
    ST_NOP
  } state_e;

  localparam int LEN_W = ID_W + 1;

  state_e                   state_q;
  logic [ID_W-1:0]          cnt_q;
  logic [1:0]               mode_q;
  logic [PRIORITY_BITS-1:0] new_prio_q;
  logic [LEN_W-1:0]         len_q;
  logic [LEN_W-1:0]         idc_q;
  logic [ID_W-1:0]          run_id_q;
  logic [PRIORITY_BITS-1:0] run_prio_q;
  logic                     run_vld_q;

  logic                     m_vld_q;
  logic [1:0]               out_status_q;
  logic [ID_W-1:0]          out_new_id_q;
  logic                     out_rvld_q;
  logic [ID_W-1:0]          out_rid_q;

  prrs_cmd_t                cmd;
  prrs_link_t               cell_link    [MAX_TASKS];
  logic [ID_W-1:0]          cell_id      [MAX_TASKS];
  logic [PRIORITY_BITS-1:0] cell_prio    [MAX_TASKS];
  logic                     cell_hit_vld [MAX_TASKS];
  logic [ID_W-1:0]          cell_hit_id  [MAX_TASKS];
  logic [PRIORITY_BITS-1:0] cell_hit_prio[MAX_TASKS];

  logic                     out_free;
  logic                     load_out;
  logic                     full;
  logic                     found;
  logic                     take_succ;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !m_vld_q || m_axis_tready_i;
  assign load_out        = out_free && (state_q inside {ST_ADD, ST_SELECT, ST_NOP});
  assign full            = (idc_q >= LEN_W'(MAX_TASKS));
  assign found           = cell_link[MAX_TASKS-1].after;
  assign take_succ       = run_vld_q && (run_prio_q >= cell_prio[0])
                           && cell_hit_vld[MAX_TASKS-1];

  always_comb begin
    cmd.insert = (state_q == ST_ADD) && out_free && !full;
    cmd.shift  = (state_q == ST_SHIFT);
  end

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    prrs_link_t               left_link;
    logic [ID_W-1:0]          left_id, right_id, left_hit_id;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio, left_hit_prio;
    logic                     left_hit_vld;

    if (i == 0) begin : g_head
      // The head cell sees a left neighbor that always stays ahead.
      assign left_link     = '{keep: 1'b1, match: 1'b0, after: 1'b0};
      assign left_id       = cell_id[i];
      assign left_prio     = cell_prio[i];
      assign left_hit_vld  = 1'b0;
      assign left_hit_id   = '0;
      assign left_hit_prio = '0;
    end else begin : g_body
      assign left_link     = cell_link[i-1];
      assign left_id       = cell_id[i-1];
      assign left_prio     = cell_prio[i-1];
      assign left_hit_vld  = cell_hit_vld[i-1];
      assign left_hit_id   = cell_hit_id[i-1];
      assign left_hit_prio = cell_hit_prio[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_tail
      assign right_id   = cell_id[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner
      assign right_id   = cell_id[i+1];
      assign right_prio = cell_prio[i+1];
    end

    prrs_cell #(
      .ID_W   (ID_W),
      .PRIO_W (PRIORITY_BITS)
    ) u_cell (
      .clk_i           (clk_i),
      .cmd_i           (cmd),
      .occupied_i      (LEN_W'(i) < len_q),
      .run_id_i        (run_id_q),
      .run_prio_i      (run_prio_q),
      .new_id_i        (idc_q[ID_W-1:0]),
      .new_prio_i      (new_prio_q),
      .left_link_i     (left_link),
      .left_id_i       (left_id),
      .left_prio_i     (left_prio),
      .right_id_i      (right_id),
      .right_prio_i    (right_prio),
      .left_hit_vld_i  (left_hit_vld),
      .left_hit_id_i   (left_hit_id),
      .left_hit_prio_i (left_hit_prio),
      .link_o          (cell_link[i]),
      .id_o            (cell_id[i]),
      .prio_o          (cell_prio[i]),
      .hit_vld_o       (cell_hit_vld[i]),
      .hit_id_o        (cell_hit_id[i]),
      .hit_prio_o      (cell_hit_prio[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      mode_q       <= MODE_ADD;
      new_prio_q   <= '0;
      len_q        <= '0;
      idc_q        <= '0;
      run_id_q     <= '0;
      run_prio_q   <= '0;
      run_vld_q    <= 1'b0;
      m_vld_q      <= 1'b0;
      out_status_q <= STATUS_OK;
      out_new_id_q <= '0;
      out_rvld_q   <= 1'b0;
      out_rid_q    <= '0;
    end else begin
      if (load_out) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            mode_q     <= s_axis_tdata_i[1:0];
            new_prio_q <= s_axis_tdata_i[2 +: PRIORITY_BITS];
            cnt_q      <= '0;
            unique case (s_axis_tdata_i[1:0])
              MODE_ADD:  state_q <= ST_ADD;
              MODE_TICK: state_q <= ST_WALK;
              MODE_EXIT: state_q <= run_vld_q ? ST_WALK : ST_SELECT;
              default:   state_q <= ST_NOP;
            endcase
          end
        end
        ST_ADD: begin
          if (out_free) begin
            out_rvld_q <= run_vld_q;
            out_rid_q  <= run_vld_q ? run_id_q : '0;
            if (full) begin
              out_status_q <= STATUS_FULL;
              out_new_id_q <= '0;
            end else begin
              out_status_q <= STATUS_OK;
              out_new_id_q <= idc_q[ID_W-1:0];
              len_q        <= len_q + LEN_W'(1);
              idc_q        <= idc_q + LEN_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        ST_WALK: begin
          // Search results reach the tail cell after one pass down the chain.
          cnt_q <= cnt_q + ID_W'(1);
          if (cnt_q == ID_W'(MAX_TASKS - 1)) begin
            state_q <= (mode_q == MODE_EXIT) ? ST_SHIFT : ST_SELECT;
          end
        end
        ST_SHIFT: begin
          if (found) begin
            len_q <= len_q - LEN_W'(1);
          end
          run_vld_q <= 1'b0;
          state_q   <= ST_SELECT;
        end
        ST_SELECT: begin
          if (out_free) begin
            out_new_id_q <= '0;
            if (len_q == '0) begin
              run_vld_q    <= 1'b0;
              run_id_q     <= '0;
              out_status_q <= STATUS_NO_TASK;
              out_rvld_q   <= 1'b0;
              out_rid_q    <= '0;
            end else begin
              run_vld_q    <= 1'b1;
              out_status_q <= STATUS_OK;
              out_rvld_q   <= 1'b1;
              if (take_succ) begin
                run_id_q   <= cell_hit_id[MAX_TASKS-1];
                run_prio_q <= cell_hit_prio[MAX_TASKS-1];
                out_rid_q  <= cell_hit_id[MAX_TASKS-1];
              end else begin
                run_id_q   <= cell_id[0];
                run_prio_q <= cell_prio[0];
                out_rid_q  <= cell_id[0];
              end
            end
            state_q <= ST_IDLE;
          end
        end
        ST_NOP: begin
          if (out_free) begin
            out_status_q <= run_vld_q ? STATUS_OK : STATUS_NO_TASK;
            out_new_id_q <= '0;
            out_rvld_q   <= run_vld_q;
            out_rid_q    <= run_vld_q ? run_id_q : '0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = OUT_TW'({out_rid_q, out_rvld_q, out_new_id_q, out_status_q});

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream-level check of the priority round-robin scheduler
// Events go in as stream beats, and a model of the task list in the bench
// predicts each result beat. The model holds its own list order, priorities,
// id numbering and running task. Results are compared in order against the
// queue of predictions. A directed opening covers the empty list, unused
// modes, equal priorities and exits. A long random run then fills the table,
// rotates among equal priorities and drains the list again. Both streams
// stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import prrs_pkg::*;

  localparam int         MAX_TASKS    = 16;
  localparam int         RANDOM_ITEMS = 1850;
  localparam int         QUIET_TAIL   = 150;   // no idling once this few events remain
  localparam int         TAIL_CYCLES  = 2 * MAX_TASKS + 8;
  localparam int         IDLE_LIMIT   = 1000;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] new_id;
    logic       run_valid;
    logic [3:0] run_id;
  } sched_result_t;

  typedef struct {
    logic [1:0] mode;
    logic [4:0] prio;
    bit         drain_first;  // hold this event until every result is back
  } sched_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;

  sched_event_t  event_queue[$];
  sched_result_t expected_results[$];
  bit            event_taken = 1'b0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            idle_cycles = 0;
  int            err_count = 0;

  // Shadow of the scheduler state.
  logic [3:0] order_q [MAX_TASKS];
  logic [4:0] prio_tab [MAX_TASKS];
  int         list_len = 0;
  int         next_id = 0;
  logic [3:0] run_id = '0;
  logic       run_valid = 1'b0;

  priority_round_robin_scheduler_top #(
    .MAX_TASKS    (MAX_TASKS),
    .PRIORITY_BITS(5)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  function automatic int find_slot(logic [3:0] id);
    for (int i = 0; i < list_len; i++) begin
      if (order_q[i] == id) return i;
    end
    return list_len;
  endfunction

  // Rotate to the list successor when it keeps the top priority, else take the head.
  function automatic void pick_next();
    int         pos;
    logic [4:0] cur_prio;
    if (list_len == 0) begin
      run_valid = 1'b0;
      run_id    = '0;
      return;
    end
    if (run_valid) begin
      cur_prio = prio_tab[run_id];
      if (cur_prio >= prio_tab[order_q[0]]) begin
        pos = find_slot(run_id);
        if (pos + 1 < list_len && prio_tab[order_q[pos+1]] >= cur_prio) begin
          run_id = order_q[pos+1];
          return;
        end
      end
    end
    run_id    = order_q[0];
    run_valid = 1'b1;
  endfunction

  function automatic void remove_running();
    int pos;
    pos = find_slot(run_id);
    if (pos >= list_len) return;
    for (int i = pos; i + 1 < list_len; i++) order_q[i] = order_q[i+1];
    list_len--;
  endfunction

  // A new task goes ahead of the first entry with lower or equal priority.
  function automatic void insert_task(logic [4:0] prio);
    int pos;
    pos = 0;
    prio_tab[next_id] = prio;
    while (pos < list_len && prio < prio_tab[order_q[pos]]) pos++;
    for (int i = list_len; i > pos; i--) order_q[i] = order_q[i-1];
    order_q[pos] = 4'(next_id);
    list_len++;
    next_id++;
  endfunction

  function automatic sched_result_t schedule_event(logic [1:0] mode, logic [4:0] prio);
    sched_result_t res;
    res.status = STATUS_OK;
    res.new_id = '0;
    case (mode)
      MODE_ADD: begin
        if (next_id >= MAX_TASKS || list_len >= MAX_TASKS) begin
          res.status = STATUS_FULL;
        end else begin
          res.new_id = 4'(next_id);
          insert_task(prio);
        end
      end
      MODE_TICK, MODE_EXIT: begin
        if (mode == MODE_EXIT && run_valid) begin
          remove_running();
          run_valid = 1'b0;
        end
        pick_next();
        res.status = run_valid ? STATUS_OK : STATUS_NO_TASK;
      end
      default: begin
        res.status = run_valid ? STATUS_OK : STATUS_NO_TASK;
      end
    endcase
    res.run_valid = run_valid;
    res.run_id    = run_valid ? run_id : 4'd0;
    return res;
  endfunction

  task automatic push_event(logic [1:0] mode, logic [4:0] prio, bit drain_first);
    sched_event_t ev;
    ev.mode        = mode;
    ev.prio        = prio;
    ev.drain_first = drain_first;
    event_queue.push_back(ev);
  endtask

  // Favor a few fixed levels so that equal priorities are common.
  function automatic logic [4:0] pick_priority();
    case ($urandom_range(0, 4))
      0, 1:    return 5'($urandom_range(0, 31));
      2:       return 5'd24;
      3:       return 5'd7;
      default: return 5'd31;
    endcase
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  // Event driver: a new beat is presented only after the previous one was taken.
  always @(negedge clk) begin : drive_events
    sched_event_t ev;
    logic         nxt_valid;
    logic [7:0]   nxt_data;
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      nxt_valid = s_valid;
      nxt_data  = s_data;
      if (!s_valid || event_taken) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (event_queue.size() > 0 &&
                     !(event_queue[0].drain_first && expected_results.size() != 0)) begin
          ev        = event_queue.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = {1'b0, ev.prio, ev.mode};
          if (event_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 12);
          end
        end
      end
      s_valid <= nxt_valid;
      s_data  <= nxt_data;
    end
  end

  // Result sink with random back-pressure bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else if (event_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 11);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted event beat, check each accepted result beat.
  always @(posedge clk) begin : monitor
    sched_result_t got;
    sched_result_t want;
    bit            result_taken;
    if (rst_n) begin
      event_taken  = s_valid && s_ready;
      result_taken = m_valid && m_ready;
      if (event_taken) begin
        expected_results.push_back(schedule_event(s_data[1:0], s_data[6:2]));
      end
      if (result_taken) begin
        got.status    = m_data[1:0];
        got.new_id    = m_data[5:2];
        got.run_valid = m_data[6];
        got.run_id    = m_data[10:7];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, m_data);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch status exp %0d act %0d, new_task_id exp %0d act %0d, %s",
                     $time, want.status, got.status, want.new_id, got.new_id,
                     $sformatf("running_valid exp %0d act %0d, running_id exp %0d act %0d",
                               want.run_valid, got.run_valid, want.run_id, got.run_id));
            err_count++;
          end
        end
      end
      if (event_taken || result_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int roll;
    int add_lim;
    int exit_lim;
    bit drain;

    // Empty list: exit with nothing running, tick and unused mode report no task.
    push_event(MODE_EXIT, 5'd31, 1'b0);
    push_event(MODE_TICK, 5'd0, 1'b0);
    push_event(MODE_UNUSED, 5'd21, 1'b0);
    push_event(MODE_ADD, 5'd31, 1'b0);
    push_event(MODE_ADD, 5'd0, 1'b0);
    push_event(MODE_UNUSED, 5'd10, 1'b0);
    push_event(MODE_TICK, 5'd0, 1'b0);
    // Equal priorities go ahead of the tasks already at that level.
    push_event(MODE_ADD, 5'd31, 1'b0);
    push_event(MODE_ADD, 5'd31, 1'b0);
    repeat (4) push_event(MODE_TICK, 5'd5, 1'b0);
    push_event(MODE_ADD, 5'd16, 1'b0);
    push_event(MODE_EXIT, 5'd0, 1'b0);
    push_event(MODE_TICK, 5'd31, 1'b0);
    push_event(MODE_EXIT, 5'd0, 1'b0);
    push_event(MODE_EXIT, 5'd0, 1'b0);
    push_event(MODE_TICK, 5'd0, 1'b0);
    push_event(MODE_UNUSED, 5'd31, 1'b0);

    // Fill the table early, rotate for a long stretch, then drain the list.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 999);
      if (n < 600) begin
        add_lim  = 40;
        exit_lim = 45;
      end else if (n < 1400) begin
        add_lim  = 20;
        exit_lim = 30;
      end else begin
        add_lim  = 20;
        exit_lim = 60;
      end
      drain = (n == 0 || n == 600 || n == 1400);
      if (roll < add_lim) push_event(MODE_ADD, pick_priority(), drain);
      else if (roll < exit_lim) push_event(MODE_EXIT, 5'($urandom_range(0, 31)), drain);
      else if (roll < exit_lim + 30)
        push_event(MODE_UNUSED, 5'($urandom_range(0, 31)), drain);
      else push_event(MODE_TICK, 5'($urandom_range(0, 31)), drain);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (event_queue.size() != 0 || s_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
